/* hw/rtl/ppt_pkg.sv */
`default_nettype none

package ppt_pkg;

  // Link words are seven bits wide; the all-ones code marks the end of a list.
  localparam int LINK_W = 7;
  localparam logic [LINK_W-1:0] NO_ENTRY = 7'd127;

  localparam int WORD_W = 32;
  localparam int VEC_W  = 3 * WORD_W;
  localparam int LIFE_W = 8;
  localparam int SLOT_W = 6;
  localparam int KIND_W = 3;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 296;
  localparam int OUT_DATA_W = 112;
  localparam int OUT_PAD_W  = OUT_DATA_W - (SLOT_W + VEC_W + LIFE_W);

  typedef enum logic [0:0] {
    OP_SPAWN = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SPAWNED = 3'd0,
    KIND_MOVED   = 3'd1,
    KIND_FREED   = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_EMPTY   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_EMPTY,
    ST_WALK,
    ST_FREE
  } state_t;

  // Source of the pool read address.
  typedef enum logic [1:0] {
    RD_FREE_HEAD,
    RD_ACTIVE_HEAD,
    RD_LINK,
    RD_NEXT_SAVED
  } rd_sel_t;

  typedef struct packed {
    logic    load_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    walk_start;
    logic    spawn;
    logic    empty;
    logic    walk_step;
    logic    free_push;
  } cmd_t;

  typedef struct packed {
    logic active_ok;
    logic out_free;
    logic expire;
    logic tail;
    logic saved_tail;
  } status_t;

endpackage

`default_nettype wire

/* hw/rtl/ppt_ctrl.sv */
`default_nettype none

module ppt_ctrl
  import ppt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire op_t     in_op,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.rd_sel     = RD_LINK;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_SPAWN) begin
            cmd.load_in = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_FREE_HEAD;
            state_nxt   = ST_SPAWN;
          end else if (status.active_ok) begin
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = RD_ACTIVE_HEAD;
            cmd.walk_start = 1'b1;
            state_nxt      = ST_WALK;
          end else begin
            state_nxt = ST_EMPTY;
          end
        end
      end
      ST_SPAWN: begin
        if (status.out_free) begin
          cmd.spawn = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (status.out_free) begin
          cmd.empty = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (status.out_free) begin
          cmd.walk_step = 1'b1;
          if (status.expire) begin
            state_nxt = ST_FREE;
          end else if (status.tail) begin
            state_nxt = ST_IDLE;
          end else begin
            // Fetch the following entry while this one is written back.
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LINK;
          end
        end
      end
      ST_FREE: begin
        cmd.free_push = 1'b1;
        if (status.saved_tail) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT_SAVED;
          state_nxt  = ST_WALK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/ppt_dpath.sv */
`default_nettype none

module ppt_dpath
  import ppt_pkg::*;
#(
  parameter int POOL_SIZE = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_DATA_W-1:0]      out_data,
  output logic [KIND_W-1:0]          out_kind,
  output logic                       out_last
);

  localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

  function automatic logic link_ok(input logic [LINK_W-1:0] l);
    return l < LINK_W'(POOL_SIZE);
  endfunction

  // List heads and walk pointers.
  logic [LINK_W-1:0] free_head_r;
  logic [LINK_W-1:0] active_head_r;
  logic [LINK_W-1:0] cur_r;
  logic [LINK_W-1:0] prev_r;
  logic [LINK_W-1:0] nxt_r;

  // Spawn item held until it is written.
  logic [VEC_W-1:0]  sp_pos_r;
  logic [VEC_W-1:0]  sp_vel_r;
  logic [VEC_W-1:0]  sp_acc_r;
  logic [LIFE_W-1:0] sp_life_r;

  // Pool memories and their registered read data.
  logic [LINK_W-1:0] link_mem [POOL_SIZE];
  logic [VEC_W-1:0]  pos_mem  [POOL_SIZE];
  logic [VEC_W-1:0]  vel_mem  [POOL_SIZE];
  logic [VEC_W-1:0]  acc_mem  [POOL_SIZE];
  logic [LIFE_W-1:0] life_mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] link_vld_r;

  logic [LINK_W-1:0] link_rd_r;
  logic [VEC_W-1:0]  pos_rd_r;
  logic [VEC_W-1:0]  vel_rd_r;
  logic [VEC_W-1:0]  acc_rd_r;
  logic [LIFE_W-1:0] life_rd_r;
  logic [IDX_W-1:0]  rd_idx_r;

  // Output register.
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [VEC_W-1:0]  out_pos_r;
  logic [LIFE_W-1:0] out_life_r;
  logic              out_last_r;

  logic [LINK_W-1:0] rd_link;
  logic [IDX_W-1:0]  rd_addr;
  logic [LINK_W-1:0] rst_link;
  logic [LINK_W-1:0] link_q;
  logic [LINK_W-1:0] nxt;
  logic [LIFE_W-1:0] life_new;
  logic [VEC_W-1:0]  pos_new;
  logic [VEC_W-1:0]  vel_new;
  logic              expire;
  logic              free_ok;
  logic              spawn_wr;
  logic              move_wr;
  logic              emit;
  logic [IDX_W-1:0]  spawn_idx;
  logic [IDX_W-1:0]  cur_idx;

  logic              link_we;
  logic [IDX_W-1:0]  link_wa;
  logic [LINK_W-1:0] link_wd;
  logic              pv_we;
  logic [IDX_W-1:0]  pv_wa;
  logic [VEC_W-1:0]  pos_wd;
  logic [VEC_W-1:0]  vel_wd;
  logic [LIFE_W-1:0] life_wd;

  assign spawn_idx = free_head_r[IDX_W-1:0];
  assign cur_idx   = cur_r[IDX_W-1:0];
  assign free_ok   = link_ok(free_head_r);
  assign spawn_wr  = cmd.spawn && free_ok;

  // A link never written still holds its reset value: the next entry, or none at the end.
  assign rst_link = (LINK_W'(rd_idx_r) + LINK_W'(1) < LINK_W'(POOL_SIZE)) ?
                    LINK_W'(rd_idx_r) + LINK_W'(1) : NO_ENTRY;
  assign link_q   = link_vld_r[rd_idx_r] ? link_rd_r : rst_link;
  assign nxt      = link_ok(link_q) ? link_q : NO_ENTRY;

  // Per-entry update: lifetime down by one, then position and velocity per axis.
  assign life_new = life_rd_r - LIFE_W'(1);
  assign expire   = (life_new == '0);
  assign move_wr  = cmd.walk_step && !expire;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pos_new[a*WORD_W +: WORD_W] = pos_rd_r[a*WORD_W +: WORD_W] + vel_rd_r[a*WORD_W +: WORD_W];
      vel_new[a*WORD_W +: WORD_W] = vel_rd_r[a*WORD_W +: WORD_W] + acc_rd_r[a*WORD_W +: WORD_W];
    end
  end

  // Read address selection.
  always_comb begin
    case (cmd.rd_sel)
      RD_FREE_HEAD:   rd_link = free_head_r;
      RD_ACTIVE_HEAD: rd_link = active_head_r;
      RD_LINK:        rd_link = nxt;
      RD_NEXT_SAVED:  rd_link = nxt_r;
      default:        rd_link = NO_ENTRY;
    endcase
  end
  assign rd_addr = rd_link[IDX_W-1:0];

  // Link write port: spawn push, unlink of an expired entry, or free-list push.
  always_comb begin
    link_we = 1'b0;
    link_wa = cur_idx;
    link_wd = free_head_r;
    if (spawn_wr) begin
      link_we = 1'b1;
      link_wa = spawn_idx;
      link_wd = active_head_r;
    end else if (cmd.walk_step && expire && link_ok(prev_r)) begin
      link_we = 1'b1;
      link_wa = prev_r[IDX_W-1:0];
      link_wd = nxt;
    end else if (cmd.free_push) begin
      link_we = 1'b1;
    end
  end

  // Particle data write port: spawn fill or move write-back.
  always_comb begin
    pv_we   = spawn_wr || move_wr;
    pv_wa   = spawn_wr ? spawn_idx : cur_idx;
    pos_wd  = spawn_wr ? sp_pos_r  : pos_new;
    vel_wd  = spawn_wr ? sp_vel_r  : vel_new;
    life_wd = spawn_wr ? sp_life_r : life_new;
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (pv_we) begin
      pos_mem[pv_wa]  <= pos_wd;
      vel_mem[pv_wa]  <= vel_wd;
      life_mem[pv_wa] <= life_wd;
    end
    if (spawn_wr) begin
      acc_mem[spawn_idx] <= sp_acc_r;
    end
    if (cmd.rd_en) begin
      link_rd_r <= link_mem[rd_addr];
      pos_rd_r  <= pos_mem[rd_addr];
      vel_rd_r  <= vel_mem[rd_addr];
      acc_rd_r  <= acc_mem[rd_addr];
      life_rd_r <= life_mem[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  // Link valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
    end else if (link_we) begin
      link_vld_r[link_wa] <= 1'b1;
    end
  end

  // Spawn item capture; a zero lifetime is stored as one.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sp_pos_r  <= in_data[VEC_W-1:0];
      sp_vel_r  <= in_data[2*VEC_W-1:VEC_W];
      sp_acc_r  <= in_data[3*VEC_W-1:2*VEC_W];
      sp_life_r <= (in_data[3*VEC_W +: LIFE_W] == '0) ? LIFE_W'(1) :
                   in_data[3*VEC_W +: LIFE_W];
    end
  end

  // List heads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r   <= '0;
      active_head_r <= NO_ENTRY;
    end else begin
      if (spawn_wr) begin
        free_head_r   <= nxt;
        active_head_r <= free_head_r;
      end else if (cmd.free_push) begin
        free_head_r <= cur_r;
      end
      if (cmd.walk_step && expire && !link_ok(prev_r)) begin
        active_head_r <= nxt;
      end
    end
  end

  // Walk pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= NO_ENTRY;
      prev_r <= NO_ENTRY;
      nxt_r  <= NO_ENTRY;
    end else if (cmd.walk_start) begin
      cur_r  <= active_head_r;
      prev_r <= NO_ENTRY;
    end else if (cmd.walk_step) begin
      if (expire) begin
        nxt_r <= nxt;
      end else begin
        cur_r  <= nxt;
        prev_r <= cur_r;
      end
    end else if (cmd.free_push) begin
      cur_r <= nxt_r;
    end
  end

  // Result register: loaded only when it is free or being taken.
  assign emit = cmd.spawn || cmd.empty || cmd.walk_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= KIND_EMPTY;
      out_slot_r <= '0;
      out_pos_r  <= '0;
      out_life_r <= '0;
      out_last_r <= 1'b1;
      if (cmd.spawn) begin
        if (free_ok) begin
          out_kind_r <= KIND_SPAWNED;
          out_slot_r <= free_head_r[SLOT_W-1:0];
          out_pos_r  <= sp_pos_r;
          out_life_r <= sp_life_r;
        end else begin
          out_kind_r <= KIND_FULL;
        end
      end else if (cmd.walk_step) begin
        out_slot_r <= cur_r[SLOT_W-1:0];
        out_last_r <= (nxt == NO_ENTRY);
        if (expire) begin
          out_kind_r <= KIND_FREED;
        end else begin
          out_kind_r <= KIND_MOVED;
          out_pos_r  <= pos_new;
          out_life_r <= life_new;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;
  assign out_data  = {{OUT_PAD_W{1'b0}}, out_life_r, out_pos_r, out_slot_r};

  // Status to the controller.
  assign status.active_ok  = link_ok(active_head_r);
  assign status.out_free   = !out_valid_r || out_ready;
  assign status.expire     = expire;
  assign status.tail       = (nxt == NO_ENTRY);
  assign status.saved_tail = (nxt_r == NO_ENTRY);

endmodule

`default_nettype wire

/* hw/rtl/particle_pool_tick.sv */
// Channel   Direction  Contents
// in_       slave      spawn or tick request; tuser selects which
// out_      master     one result per spawn, per visited particle, or per empty tick
//
// A spawn reads the free-list head, then writes the new entry or reports a full pool.
// A tick walks the active list one entry per step through the pool memories: a moving
// particle is written back in a WALK step, an expiring one is unlinked there and then
// pushed onto the free list in a FREE step. A tick with no active particle uses EMPTY.
// Synchronous active-low reset sets up the free list; no clearing pass is needed.
// A stalled output holds the walk; the next item is taken once the last result
// of the current one is in the output register.
`default_nettype none

module particle_pool_tick
  import ppt_pkg::*;
#(
  parameter int POOL_SIZE = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, lifetime
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  wire logic [0:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // slot, out_x, out_y, out_z, ticks_left, zero fill
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // kind
  output logic [KIND_W-1:0]          out_tuser,
  output logic                       out_tlast
);

  cmd_t    cmd;
  status_t status;

  ppt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (op_t'(in_tuser)),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ppt_dpath #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_kind  (out_tuser),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire
